// ----- rtl/core/i2cm_pkg.sv -----
// Shared types and phase codes for the I2C master byte transfer block.
// Used by i2cm_step and by the top level i2c_master_byte_transfer.
// No dependencies.
package i2cm_pkg;

  localparam logic [4:0] PH_IDLE        = 5'd0;
  localparam logic [4:0] PH_START       = 5'd1;
  localparam logic [4:0] PH_TX_SCL_LOW  = 5'd2;
  localparam logic [4:0] PH_TX_SDA      = 5'd3;
  localparam logic [4:0] PH_TX_SCL_HIGH = 5'd4;
  localparam logic [4:0] PH_AK_SCL_LOW  = 5'd5;
  localparam logic [4:0] PH_AK_SDA_REL  = 5'd6;
  localparam logic [4:0] PH_AK_SCL_HIGH = 5'd7;
  localparam logic [4:0] PH_AK_SAMPLE   = 5'd8;
  localparam logic [4:0] PH_RX_SCL_LOW  = 5'd9;
  localparam logic [4:0] PH_RX_SDA_REL  = 5'd10;
  localparam logic [4:0] PH_RB_SCL_LOW  = 5'd11;
  localparam logic [4:0] PH_RB_SCL_HIGH = 5'd12;
  localparam logic [4:0] PH_RB_SAMPLE   = 5'd13;
  localparam logic [4:0] PH_SA_SCL_LOW  = 5'd14;
  localparam logic [4:0] PH_SA_SDA      = 5'd15;
  localparam logic [4:0] PH_SA_SCL_HIGH = 5'd16;
  localparam logic [4:0] PH_SP_SCL_LOW  = 5'd17;
  localparam logic [4:0] PH_SP_SDA_LOW  = 5'd18;
  localparam logic [4:0] PH_SP_SCL_HIGH = 5'd19;
  localparam logic [4:0] PH_SP_SDA_HIGH = 5'd20;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ADDR_NACK = 2'd1;
  localparam logic [1:0] ST_DATA_NACK = 2'd2;

  typedef struct packed {
    logic [4:0]  phase;
    logic [2:0]  bit_index;
    logic [7:0]  shift_reg;
    logic [15:0] bytes_left;
    logic        read_mode;
    logic [15:0] divider;
    logic        scl_level;
    logic        sda_level;
    logic        addr_stage;
    logic        nack_seen;
    logic [1:0]  status;
  } i2cm_state_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       tx_take;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       done_res;
    logic [1:0] status;
  } i2cm_res_t;

endpackage

// ----- rtl/core/i2cm_step.sv -----
// Next-state and result logic for one tick of the I2C master sequencer.
// Depends on i2cm_pkg for the phase codes and the state and result types.
module i2cm_step (
  input  i2cm_pkg::i2cm_state_t st_i,
  input  logic [15:0]           phase_ticks_i,
  input  logic                  start_req_i,
  input  logic                  is_read_i,
  input  logic [7:0]            dev_addr_i,
  input  logic [15:0]           byte_count_i,
  input  logic [7:0]            tx_byte_i,
  input  logic                  sda_in_i,
  output i2cm_pkg::i2cm_state_t st_o,
  output i2cm_pkg::i2cm_res_t   res_o
);
  import i2cm_pkg::*;

  i2cm_state_t s;
  logic [4:0]  nph;
  logic        ent;
  logic        take;
  logic        rxv;
  logic [7:0]  rxb;
  logic        done;
  logic [15:0] hold;
  logic [15:0] div_inc;

  always_comb begin
    s       = st_i;
    nph     = st_i.phase;
    ent     = 1'b0;
    take    = 1'b0;
    rxv     = 1'b0;
    rxb     = 8'h00;
    done    = 1'b0;
    hold    = (phase_ticks_i == 16'd0) ? 16'd1 : phase_ticks_i;
    div_inc = st_i.divider + 16'd1;

    if (st_i.phase == PH_IDLE) begin
      if (start_req_i) begin
        s.read_mode  = is_read_i;
        s.shift_reg  = is_read_i ? (dev_addr_i | 8'h01) : (dev_addr_i & 8'hfe);
        s.bytes_left = (is_read_i && byte_count_i == 16'd0) ? 16'd1 : byte_count_i;
        s.bit_index  = 3'd0;
        s.addr_stage = 1'b1;
        s.nack_seen  = 1'b0;
        s.status     = ST_OK;
        ent          = 1'b1;
        nph          = PH_START;
      end
    end else begin
      s.divider = div_inc;
      if (div_inc >= hold || div_inc == 16'd0) begin
        ent = 1'b1;
        case (st_i.phase)
          PH_START:       nph = PH_TX_SCL_LOW;
          PH_TX_SCL_LOW:  nph = PH_TX_SDA;
          PH_TX_SDA:      nph = PH_TX_SCL_HIGH;
          PH_TX_SCL_HIGH: begin
            if (st_i.bit_index == 3'd7) begin
              nph = PH_AK_SCL_LOW;
            end else begin
              s.bit_index = st_i.bit_index + 3'd1;
              s.shift_reg = {st_i.shift_reg[6:0], 1'b0};
              nph         = PH_TX_SCL_LOW;
            end
          end
          PH_AK_SCL_LOW:  nph = PH_AK_SDA_REL;
          PH_AK_SDA_REL:  nph = PH_AK_SCL_HIGH;
          PH_AK_SCL_HIGH: nph = PH_AK_SAMPLE;
          PH_AK_SAMPLE: begin
            if (st_i.nack_seen) begin
              s.status = st_i.addr_stage ? ST_ADDR_NACK : ST_DATA_NACK;
              nph      = PH_SP_SCL_LOW;
            end else begin
              if (st_i.addr_stage) begin
                s.addr_stage = 1'b0;
              end else begin
                s.bytes_left = st_i.bytes_left - 16'd1;
              end
              if (st_i.addr_stage && st_i.read_mode) begin
                nph = PH_RX_SCL_LOW;
              end else if (s.bytes_left == 16'd0) begin
                nph = PH_SP_SCL_LOW;
              end else begin
                s.shift_reg = tx_byte_i;
                s.bit_index = 3'd0;
                take        = 1'b1;
                nph         = PH_TX_SCL_LOW;
              end
            end
          end
          PH_RX_SCL_LOW:  nph = PH_RX_SDA_REL;
          PH_RX_SDA_REL: begin
            s.bit_index = 3'd0;
            s.shift_reg = 8'h00;
            nph         = PH_RB_SCL_LOW;
          end
          PH_RB_SCL_LOW:  nph = PH_RB_SCL_HIGH;
          PH_RB_SCL_HIGH: nph = PH_RB_SAMPLE;
          PH_RB_SAMPLE: begin
            if (st_i.bit_index == 3'd7) begin
              nph = PH_SA_SCL_LOW;
            end else begin
              s.bit_index = st_i.bit_index + 3'd1;
              nph         = PH_RB_SCL_LOW;
            end
          end
          PH_SA_SCL_LOW:  nph = PH_SA_SDA;
          PH_SA_SDA:      nph = PH_SA_SCL_HIGH;
          PH_SA_SCL_HIGH: begin
            s.bytes_left = st_i.bytes_left - 16'd1;
            nph = (s.bytes_left == 16'd0) ? PH_SP_SCL_LOW : PH_RX_SCL_LOW;
          end
          PH_SP_SCL_LOW:  nph = PH_SP_SDA_LOW;
          PH_SP_SDA_LOW:  nph = PH_SP_SCL_HIGH;
          PH_SP_SCL_HIGH: nph = PH_SP_SDA_HIGH;
          default: begin
            ent       = 1'b0;
            s.phase   = PH_IDLE;
            s.divider = 16'd0;
            done      = 1'b1;
          end
        endcase
      end
    end

    // The pin action and any sample of a phase happen on the tick that enters it.
    if (ent) begin
      s.phase   = nph;
      s.divider = 16'd0;
      case (nph)
        PH_START:       s.sda_level = 1'b0;
        PH_TX_SCL_LOW:  s.scl_level = 1'b0;
        PH_TX_SDA:      s.sda_level = s.shift_reg[7];
        PH_TX_SCL_HIGH: s.scl_level = 1'b1;
        PH_AK_SCL_LOW:  s.scl_level = 1'b0;
        PH_AK_SDA_REL:  s.sda_level = 1'b1;
        PH_AK_SCL_HIGH: s.scl_level = 1'b1;
        PH_AK_SAMPLE:   s.nack_seen = sda_in_i;
        PH_RX_SCL_LOW:  s.scl_level = 1'b0;
        PH_RX_SDA_REL:  s.sda_level = 1'b1;
        PH_RB_SCL_LOW:  s.scl_level = 1'b0;
        PH_RB_SCL_HIGH: s.scl_level = 1'b1;
        PH_RB_SAMPLE: begin
          s.shift_reg = {s.shift_reg[6:0], sda_in_i};
          if (s.bit_index == 3'd7) begin
            rxv = 1'b1;
            rxb = s.shift_reg;
          end
        end
        PH_SA_SCL_LOW:  s.scl_level = 1'b0;
        PH_SA_SDA:      s.sda_level = (s.bytes_left <= 16'd1);
        PH_SA_SCL_HIGH: s.scl_level = 1'b1;
        PH_SP_SCL_LOW:  s.scl_level = 1'b0;
        PH_SP_SDA_LOW:  s.sda_level = 1'b0;
        PH_SP_SCL_HIGH: s.scl_level = 1'b1;
        PH_SP_SDA_HIGH: s.sda_level = 1'b1;
        default:        s.phase     = nph;
      endcase
    end
  end

  assign st_o           = s;
  assign res_o.scl_out  = s.scl_level;
  assign res_o.sda_out  = s.sda_level;
  assign res_o.busy_res = (s.phase != PH_IDLE);
  assign res_o.tx_take  = take;
  assign res_o.rx_byte  = rxb;
  assign res_o.rx_valid = rxv;
  assign res_o.done_res = done;
  assign res_o.status   = done ? s.status : ST_OK;

endmodule

// ----- rtl/core/i2c_master_byte_transfer.sv -----
// Top level of the I2C master byte transfer block: handshakes, state and result registers.
// Depends on i2cm_pkg and instantiates i2cm_step.

// Each input item is one tick of the bus sequencer and yields exactly one result item.
// An item is taken every cycle while the output is not stalled: the sequencer state advances
// in one registered step, and the result register takes the new result only when no result
// waits or the waiting one is taken in that cycle. Output backpressure stalls input.
// The phase_ticks register sets how many ticks each SCL or SDA phase lasts; zero acts as one.
module i2c_master_byte_transfer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        start_req_i,
  input  logic        is_read_i,
  input  logic [7:0]  dev_addr_i,
  input  logic [15:0] byte_count_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        sda_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        scl_out_o,
  output logic        sda_out_o,
  output logic        busy_res_o,
  output logic        tx_take_o,
  output logic [7:0]  rx_byte_o,
  output logic        rx_valid_o,
  output logic        done_res_o,
  output logic [1:0]  status_o
);
  import i2cm_pkg::*;

  i2cm_state_t st_q;
  i2cm_state_t st_d;
  i2cm_res_t   res_d;
  i2cm_res_t   res_q;
  logic [15:0] phase_ticks_q;
  logic        out_valid_q;
  logic        in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  i2cm_step u_step (
    .st_i          (st_q),
    .phase_ticks_i (phase_ticks_q),
    .start_req_i   (start_req_i),
    .is_read_i     (is_read_i),
    .dev_addr_i    (dev_addr_i),
    .byte_count_i  (byte_count_i),
    .tx_byte_i     (tx_byte_i),
    .sda_in_i      (sda_in_i),
    .st_o          (st_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q <= 16'd1;
    end else if (cfg_valid_i) begin
      phase_ticks_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase: PH_IDLE, bit_index: 3'd0, shift_reg: 8'h00, bytes_left: 16'd0,
                read_mode: 1'b0, divider: 16'd0, scl_level: 1'b1, sda_level: 1'b1,
                addr_stage: 1'b0, nack_seen: 1'b0, status: ST_OK};
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        st_q <= st_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign scl_out_o   = res_q.scl_out;
  assign sda_out_o   = res_q.sda_out;
  assign busy_res_o  = res_q.busy_res;
  assign tx_take_o   = res_q.tx_take;
  assign rx_byte_o   = res_q.rx_byte;
  assign rx_valid_o  = res_q.rx_valid;
  assign done_res_o  = res_q.done_res;
  assign status_o    = res_q.status;

endmodule
